// ----- sv/triangle_incircle_top_defines.svh -----
// Assertion macros used by the triangle incircle top level.
`ifndef TRIANGLE_INCIRCLE_TOP_DEFINES_SVH
`define TRIANGLE_INCIRCLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TIC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TIC_ASSERT_NXT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tic_pkg.sv -----
// Shared widths and types of the triangle incircle pipeline.
package tic_pkg;

    localparam int COORD_W     = 16;
    localparam int NUM_COORD   = 9;
    localparam int GUARD_BITS  = 3;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int SSQ_W       = SQ_W + 2;
    localparam int SIDE_IN_W   = SSQ_W + 2 * GUARD_BITS;
    localparam int SIDE_W      = SIDE_IN_W / 2;
    localparam int PER_W       = SIDE_W + 2;
    localparam int PROD_W      = COORD_W + SIDE_W + 1;
    localparam int NUM_W       = PROD_W + 2;
    localparam int MAG_W       = NUM_W - 1;
    localparam int UV_W        = 2 * PER_W;
    localparam int PP_W        = 2 * PER_W;
    localparam int PSUM_W      = 3 * PER_W;
    localparam int RDIV_NW     = 58;
    localparam int CQ_W        = COORD_W + 1;
    localparam int RROOT_W     = COORD_W + GUARD_BITS;
    localparam int RQ_W        = 2 * RROOT_W;
    localparam int PRE_STAGES  = 8;

    localparam logic [CQ_W-1:0] POS_LIMIT = CQ_W'(32767);
    localparam logic [CQ_W-1:0] NEG_LIMIT = CQ_W'(32768);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [NUM_COORD-1:0][COORD_W-1:0] vtx_bus_t;

endpackage

// ----- sv/tic_delay.sv -----
// Enabled delay line that carries a valid bit beside its data.
module tic_delay import tic_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         valid_reg [DEPTH];
    logic [W-1:0] data_reg  [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_tap
        logic         valid_cur;
        logic [W-1:0] data_cur;
        if (k == 0) begin : g_first
            assign valid_cur = in_valid;
            assign data_cur  = in_data;
        end else begin : g_next
            assign valid_cur = valid_reg[k-1];
            assign data_cur  = data_reg[k-1];
        end

        // Each tap advances only while the pipeline moves.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                data_reg[k] <= data_cur;
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

// ----- sv/tic_isqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage.
module tic_isqrt_pipe import tic_pkg::*; #(
    parameter int IW = SIDE_IN_W
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [IW-1:0]   din,
    output logic [IW/2-1:0] root
);

    localparam int OW = IW / 2;
    localparam int RW = OW + 2;

    logic [RW-1:0] rem_reg  [OW];
    logic [OW-1:0] root_reg [OW];
    logic [IW-1:0] low_reg  [OW];

    for (genvar k = 0; k < OW; k++) begin : g_step
        logic [RW-1:0] rem_cur;
        logic [OW-1:0] root_cur;
        logic [IW-1:0] low_cur;
        logic [RW+1:0] trial_rem;
        logic [RW+1:0] trial_sub;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign low_cur  = din;
        end else begin : g_next
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign low_cur  = low_reg[k-1];
        end

        // Bring down the next bit pair and try the candidate root bit.
        assign trial_rem = {rem_cur, low_cur[IW-1 -: 2]};
        assign trial_sub = {{(RW-OW){1'b0}}, root_cur, 2'b01};
        assign take      = (trial_rem >= trial_sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? RW'(trial_rem - trial_sub) : RW'(trial_rem);
                root_reg[k] <= {root_cur[OW-2:0], take};
                low_reg[k]  <= {low_cur[IW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[OW-1];

endmodule

// ----- sv/tic_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module tic_div_pipe import tic_pkg::*; #(
    parameter int NW = MAG_W,
    parameter int QW = CQ_W,
    parameter int DW = PER_W
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    // The caller guarantees the quotient fits in QW bits, so the upper
    // dividend bits start out below the divisor.
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] div_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] rem_cur;
        logic [QW-1:0] low_cur;
        logic [DW-1:0] div_cur;
        logic [DW:0]   trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_cur = DW'(dividend[NW-1:QW]);
            assign low_cur = dividend[QW-1:0];
            assign div_cur = divisor;
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign low_cur = low_reg[k-1];
            assign div_cur = div_reg[k-1];
        end

        // Shift in the next dividend bit and subtract when it fits.
        assign trial = {rem_cur, low_cur[QW-1]};
        assign take  = (trial >= {1'b0, div_cur});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? DW'(trial - {1'b0, div_cur}) : DW'(trial);
                low_reg[k] <= {low_cur[QW-2:0], take};
                div_reg[k] <= div_cur;
            end
        end
    end

    assign quotient = low_reg[QW-1];

endmodule

// ----- sv/triangle_incircle_top.sv -----
// Top level of the triangle incircle unit: front stages, roots, dividers, output.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_ax s_ay s_az s_bx s_by s_bz s_cx s_cy s_cz
//  m_      | out       | m_valid / m_ready | m_center_x/y/z m_inradius m_degenerate
//
// One item can enter every cycle while no stall on m_ready holds the pipeline. The
// path to m_valid is 86 register stages: 3 front stages, the 20-stage side
// root, 5 stages for the perimeter, radius factors and products, the 38-stage radius
// divider, the 19-stage radius root and the output register.
// Reset clears every valid bit; data registers are not reset.
// A stall on m_ready freezes the whole pipeline, so s_ready follows it at once.
`include "triangle_incircle_top_defines.svh"

module triangle_incircle_top import tic_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_ax,
    input  logic signed [COORD_W-1:0] s_ay,
    input  logic signed [COORD_W-1:0] s_az,
    input  logic signed [COORD_W-1:0] s_bx,
    input  logic signed [COORD_W-1:0] s_by,
    input  logic signed [COORD_W-1:0] s_bz,
    input  logic signed [COORD_W-1:0] s_cx,
    input  logic signed [COORD_W-1:0] s_cy,
    input  logic signed [COORD_W-1:0] s_cz,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_center_x,
    output logic signed [COORD_W-1:0] m_center_y,
    output logic signed [COORD_W-1:0] m_center_z,
    output logic        [COORD_W-1:0] m_inradius,
    output logic                      m_degenerate
);

    localparam int TAIL_DEPTH = RQ_W + RROOT_W - CQ_W;

    logic en;

    // Pipeline advances whenever the output register is free or being taken.
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 1: capture vertices and form the edge differences.
    coord_t                   vtx_in  [NUM_COORD];
    logic                     v1_reg;
    vtx_bus_t                 vtx1_reg;
    logic signed [DIFF_W-1:0] d1_reg  [NUM_COORD];
    logic signed [DIFF_W-1:0] d1_next [NUM_COORD];

    assign vtx_in[0] = s_ax;
    assign vtx_in[1] = s_ay;
    assign vtx_in[2] = s_az;
    assign vtx_in[3] = s_bx;
    assign vtx_in[4] = s_by;
    assign vtx_in[5] = s_bz;
    assign vtx_in[6] = s_cx;
    assign vtx_in[7] = s_cy;
    assign vtx_in[8] = s_cz;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1_next[k]   = DIFF_W'(vtx_in[3+k]) - DIFF_W'(vtx_in[k]);
            d1_next[3+k] = DIFF_W'(vtx_in[6+k]) - DIFF_W'(vtx_in[3+k]);
            d1_next[6+k] = DIFF_W'(vtx_in[k])   - DIFF_W'(vtx_in[6+k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NUM_COORD; j++) begin
                vtx1_reg[j] <= vtx_in[j];
                d1_reg[j]   <= d1_next[j];
            end
        end
    end

    // Stage 2: square every difference.
    logic [SQ_W-1:0]            sq2_reg  [NUM_COORD];
    logic signed [2*DIFF_W-1:0] sq_full  [NUM_COORD];

    always_comb begin
        for (int j = 0; j < NUM_COORD; j++) begin
            sq_full[j] = (2*DIFF_W)'(d1_reg[j]) * (2*DIFF_W)'(d1_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NUM_COORD; j++) begin
                sq2_reg[j] <= sq_full[j][SQ_W-1:0];
            end
        end
    end

    // Stage 3: squared edge lengths.
    logic [SSQ_W-1:0] ss3_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < 3; s++) begin
                ss3_reg[s] <= SSQ_W'(sq2_reg[3*s]) + SSQ_W'(sq2_reg[3*s+1])
                            + SSQ_W'(sq2_reg[3*s+2]);
            end
        end
    end

    // Edge lengths with guard fraction bits; vertices wait beside them.
    logic [SIDE_W-1:0] side [3];
    logic              vd_valid;
    vtx_bus_t          vtx_d;

    for (genvar s = 0; s < 3; s++) begin : g_side
        tic_isqrt_pipe #(.IW(SIDE_IN_W)) u_side_root (
            .aclk (aclk),
            .en   (en),
            .din  ({ss3_reg[s], {(2*GUARD_BITS){1'b0}}}),
            .root (side[s])
        );
    end

    tic_delay #(.W(NUM_COORD*COORD_W), .DEPTH(2 + SIDE_W)) u_vtx_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_data   (vtx1_reg),
        .out_valid (vd_valid),
        .out_data  (vtx_d)
    );

    // Stage 4: perimeter.
    logic              v4_reg;
    logic [PER_W-1:0]  per4_reg;
    logic [SIDE_W-1:0] side4_reg [3];
    vtx_bus_t          vtx4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            per4_reg <= PER_W'(side[0]) + PER_W'(side[1]) + PER_W'(side[2]);
            for (int s = 0; s < 3; s++) begin
                side4_reg[s] <= side[s];
            end
            vtx4_reg <= vtx_d;
        end
    end

    // Stage 5: radius factors and weighted vertex products.
    logic                     v5_reg;
    logic [PER_W-1:0]         per5_reg;
    logic [PER_W-1:0]         uvw5_reg  [3];
    logic [PER_W-1:0]         uvw_next  [3];
    logic signed [PROD_W-1:0] pm5_reg   [NUM_COORD];
    logic signed [PROD_W-1:0] pm_next   [NUM_COORD];

    always_comb begin
        logic signed [PER_W+1:0] diff;
        for (int s = 0; s < 3; s++) begin
            diff = $signed({2'b00, per4_reg}) - $signed({3'b000, side4_reg[s], 1'b0});
            uvw_next[s] = diff[PER_W+1] ? '0 : diff[PER_W-1:0];
        end
        // Vertex A is weighted by BC, B by CA and C by AB.
        for (int j = 0; j < NUM_COORD; j++) begin
            pm_next[j] = PROD_W'($signed(vtx4_reg[j]))
                       * $signed(PROD_W'({1'b0, side4_reg[((j/3)+1)%3]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            per5_reg <= per4_reg;
            for (int s = 0; s < 3; s++) begin
                uvw5_reg[s] <= uvw_next[s];
            end
            for (int j = 0; j < NUM_COORD; j++) begin
                pm5_reg[j] <= pm_next[j];
            end
        end
    end

    // Stage 6: center numerators and the first radius product.
    logic                    v6_reg;
    logic [PER_W-1:0]        per6_reg;
    logic                    degen6_reg;
    logic signed [NUM_W-1:0] num6_reg [3];
    logic [UV_W-1:0]         uv6_reg;
    logic [PER_W-1:0]        w6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            per6_reg   <= per5_reg;
            degen6_reg <= (per5_reg == '0);
            for (int k = 0; k < 3; k++) begin
                num6_reg[k] <= NUM_W'(pm5_reg[k]) + NUM_W'(pm5_reg[3+k])
                             + NUM_W'(pm5_reg[6+k]);
            end
            uv6_reg <= UV_W'(uvw5_reg[0]) * UV_W'(uvw5_reg[1]);
            w6_reg  <= uvw5_reg[2];
        end
    end

    // Stage 7: numerator magnitudes and the split second radius product.
    logic                    v7_reg;
    logic [PER_W-1:0]        per7_reg;
    logic                    degen7_reg;
    logic [MAG_W-1:0]        mag7_reg [3];
    logic [2:0]              neg7_reg;
    logic [PP_W-1:0]         ph7_reg;
    logic [PP_W-1:0]         pl7_reg;
    logic signed [NUM_W-1:0] abs_num  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_num[k] = num6_reg[k][NUM_W-1] ? -num6_reg[k] : num6_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            per7_reg   <= per6_reg;
            degen7_reg <= degen6_reg;
            for (int k = 0; k < 3; k++) begin
                mag7_reg[k] <= abs_num[k][MAG_W-1:0];
                neg7_reg[k] <= num6_reg[k][NUM_W-1];
            end
            ph7_reg <= PP_W'(uv6_reg[UV_W-1:PER_W]) * PP_W'(w6_reg);
            pl7_reg <= PP_W'(uv6_reg[PER_W-1:0]) * PP_W'(w6_reg);
        end
    end

    // Stage 8: full radius product divided by four.
    logic                v8_reg;
    logic [PER_W-1:0]    per8_reg;
    logic                degen8_reg;
    logic [MAG_W-1:0]    mag8_reg [3];
    logic [2:0]          neg8_reg;
    logic [RDIV_NW-1:0]  rdvd8_reg;
    logic [PSUM_W-1:0]   psum;

    assign psum = {ph7_reg, {PER_W{1'b0}}} + PSUM_W'(pl7_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            per8_reg   <= per7_reg;
            degen8_reg <= degen7_reg;
            neg8_reg   <= neg7_reg;
            for (int k = 0; k < 3; k++) begin
                mag8_reg[k] <= mag7_reg[k];
            end
            rdvd8_reg <= psum[RDIV_NW+1:2];
        end
    end

    // Valid bits of stages 4 to 8.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vd_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // Center dividers and the radius divider share the perimeter.
    logic [CQ_W-1:0]    cq [3];
    logic [RQ_W-1:0]    rq;
    logic [RROOT_W-1:0] rroot;

    for (genvar k = 0; k < 3; k++) begin : g_cdiv
        tic_div_pipe #(.NW(MAG_W), .QW(CQ_W), .DW(PER_W)) u_center_div (
            .aclk     (aclk),
            .en       (en),
            .dividend (mag8_reg[k]),
            .divisor  (per8_reg),
            .quotient (cq[k])
        );
    end

    tic_div_pipe #(.NW(RDIV_NW), .QW(RQ_W), .DW(PER_W)) u_radius_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (rdvd8_reg),
        .divisor  (per8_reg),
        .quotient (rq)
    );

    tic_isqrt_pipe #(.IW(RQ_W)) u_radius_root (
        .aclk (aclk),
        .en   (en),
        .din  (rq),
        .root (rroot)
    );

    // Signs and the degenerate flag travel beside the center dividers.
    logic       cd_valid;
    logic [3:0] cd_side;

    tic_delay #(.W(4), .DEPTH(CQ_W)) u_flag_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v8_reg),
        .in_data   ({neg8_reg, degen8_reg}),
        .out_valid (cd_valid),
        .out_data  (cd_side)
    );

    // Center results wait for the radius divider and root.
    logic                      fin_valid;
    logic [3*CQ_W+3:0]         fin_data;
    logic [CQ_W-1:0]           fq [3];
    logic [2:0]                fneg;
    logic                      fdegen;

    tic_delay #(.W(3*CQ_W + 4), .DEPTH(TAIL_DEPTH)) u_center_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cd_valid),
        .in_data   ({cq[2], cq[1], cq[0], cd_side}),
        .out_valid (fin_valid),
        .out_data  (fin_data)
    );

    assign fdegen = fin_data[0];
    assign fneg   = fin_data[3:1];
    assign fq[0]  = fin_data[CQ_W+3:4];
    assign fq[1]  = fin_data[2*CQ_W+3:CQ_W+4];
    assign fq[2]  = fin_data[3*CQ_W+3:2*CQ_W+4];

    // Apply signs, saturate, and zero everything for a degenerate triangle.
    logic [COORD_W-1:0] ctr_next [3];
    logic [COORD_W-1:0] rad_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (fdegen) begin
                ctr_next[k] = '0;
            end else if (fneg[k]) begin
                ctr_next[k] = (fq[k] > NEG_LIMIT) ? {1'b1, {(COORD_W-1){1'b0}}}
                                                 : COORD_W'(-fq[k]);
            end else begin
                ctr_next[k] = (fq[k] > POS_LIMIT) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                 : fq[k][COORD_W-1:0];
            end
        end
        rad_next = fdegen ? '0 : rroot[RROOT_W-1:GUARD_BITS];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_center_x   <= ctr_next[0];
            m_center_y   <= ctr_next[1];
            m_center_z   <= ctr_next[2];
            m_inradius   <= rad_next;
            m_degenerate <= fdegen;
        end
    end

    assign m_valid = m_valid_reg;

    // Checks on the pipeline control and the degenerate outputs.
    `TIC_ASSERT_IMP(a_degen_zero, aclk, aresetn, m_valid && m_degenerate,
        m_center_x == '0 && m_center_y == '0 && m_center_z == '0 && m_inradius == '0,
        "degenerate item carries nonzero fields")
    `TIC_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, v1_reg,
        "accepted item did not enter the first stage")
    `TIC_ASSERT_NXT(a_stall_holds, aclk, aresetn, !en, $stable(v8_reg) && $stable(v1_reg),
        "pipeline moved during a stall")
    `TIC_ASSERT_NXT_ANY(a_reset_empty, aclk, !aresetn, !m_valid && !v1_reg,
        "valid bits not cleared by reset")

endmodule
